FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("assertion failed");

// When pre holds, post holds in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("assertion failed");

// When pre holds, post holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_IMPLIES(lbl, clk, rstn, pre, post)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post)

`endif

`endif

FILE: rtl/odo_pkg.sv
`timescale 1ns / 1ps

package odo_pkg;

  // Pose and gain widths fixed by the register map.
  localparam int POS_W   = 48;
  localparam int GAIN_W  = 24;
  localparam int HEAD_W  = 32;
  localparam int OUT_W   = 2 * POS_W + HEAD_W;

  // Configuration port.
  localparam int CFG_DW  = 64;
  localparam int CFG_AW  = 6;

  localparam logic [2:0] REG_DISTANCE_GAIN = 3'd0;
  localparam logic [2:0] REG_HEADING_GAIN  = 3'd1;
  localparam logic [2:0] REG_START_X       = 3'd2;
  localparam logic [2:0] REG_START_Y       = 3'd3;
  localparam logic [2:0] REG_START_HEADING = 3'd4;

  // CORDIC rotation engine.
  localparam int CW           = 34;
  localparam int CORDIC_ITERS = 28;
  localparam int ITER_W       = 5;
  localparam logic [31:0] CORDIC_K = 32'd652032874;

  // Bit-serial multiplier: one bit of the sine or cosine magnitude per cycle.
  localparam int MUL_BITS = 32;
  localparam int MUL_CNT_W = 5;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } odo_quad_t;

  // Arctangent of 2^-i in binary-angle units where 2^32 is a full turn.
  function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/odo_cordic.sv
`timescale 1ns / 1ps

// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module odo_cordic import odo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic [31:0]          ang_i,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o,
  output logic                 done_o
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [ITER_W-1:0]     iter_r, iter_nxt;
  logic signed [CW-1:0]  x_r, x_nxt;
  logic signed [CW-1:0]  y_r, y_nxt;
  logic signed [CW-1:0]  z_r, z_nxt;
  odo_quad_t             quad_r, quad_nxt;

  logic signed [CW-1:0]  xs, ys, at;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    quad_nxt = quad_r;
    xs = x_r >>> iter_r;
    ys = y_r >>> iter_r;
    at = CW'(atan_entry(iter_r));
    if (start_i) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      x_nxt    = CW'(CORDIC_K);
      y_nxt    = '0;
      z_nxt    = CW'(ang_i[29:0]);
      quad_nxt = odo_quad_t'(ang_i[31:30]);
    end else if (busy_r) begin
      if (!z_r[CW-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      iter_nxt = iter_r + 1'b1;
      if (iter_r == ITER_W'(CORDIC_ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    quad_r <= quad_nxt;
  end

  // Fold the first-quadrant result back to the full circle.
  always_comb begin
    unique case (quad_r)
      QUAD_I: begin
        cos_o = x_r;
        sin_o = y_r;
      end
      QUAD_II: begin
        cos_o = -y_r;
        sin_o = x_r;
      end
      QUAD_III: begin
        cos_o = -x_r;
        sin_o = -y_r;
      end
      default: begin
        cos_o = y_r;
        sin_o = -x_r;
      end
    endcase
  end

  assign done_o = done_r;

endmodule

FILE: rtl/odo_sermul.sv
`timescale 1ns / 1ps

// Bit-serial shift-add multiplier giving t * c / 2^31 truncated toward zero.
module odo_sermul import odo_pkg::*; #(
  parameter int T_W = 42
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic signed [T_W-1:0] t_i,
  input  logic signed [CW-1:0]  c_i,
  output logic signed [T_W:0]   d_o,
  output logic                  done_o
);

  localparam int P_W = T_W + MUL_BITS + 1;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [T_W-1:0]       ut_r, ut_nxt;
  logic [P_W-1:0]       p_r, p_nxt;
  logic                 neg_r, neg_nxt;

  logic [T_W-1:0]       t_mag;
  logic [CW-1:0]        c_mag;
  logic [T_W:0]         acc;
  logic [T_W:0]         quo;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    ut_nxt   = ut_r;
    p_nxt    = p_r;
    neg_nxt  = neg_r;
    t_mag = t_i[T_W-1] ? T_W'(-t_i) : T_W'(t_i);
    c_mag = c_i[CW-1] ? CW'(-c_i) : CW'(c_i);
    acc = p_r[P_W-2:MUL_BITS] + (p_r[0] ? {1'b0, ut_r} : '0);
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      ut_nxt   = t_mag;
      neg_nxt  = t_i[T_W-1] ^ c_i[CW-1];
      p_nxt    = {{(T_W + 1){1'b0}}, c_mag[MUL_BITS-1:0]};
    end else if (busy_r) begin
      p_nxt   = {1'b0, acc, p_r[MUL_BITS-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MUL_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ut_r  <= ut_nxt;
    p_r   <= p_nxt;
    neg_r <= neg_nxt;
  end

  // Product bits from 2^31 upwards; the quotient stays below 2^T_W.
  assign quo    = p_r[P_W-2:MUL_BITS-1];
  assign d_o    = neg_r ? -$signed(quo) : $signed(quo);
  assign done_o = done_r;

endmodule

FILE: rtl/differential_drive_odometry.sv
// An accepted input beat runs 28 CORDIC iterations, then 32 bit-serial multiply steps
// in both multipliers, then the pose update that raises out_tvalid. Only one update is in
// flight at a time: in_tready is high only while the controller is idle.
// A finished result waits in the output register while the next input beat is taken;
// the pose only moves on once that register is free, so a slow receiver stretches the cycle.
// Reset is synchronous on rst_n: gains, start registers and the pose all return to zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module differential_drive_odometry import odo_pkg::*; #(
  parameter int COUNT_BITS = 16,
  parameter int ANGLE_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input beat.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // tdata: left_count, right_count (COUNT_BITS each, signed), zero padded to bytes.
  input  logic [((2 * COUNT_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // Result beat.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // tdata: x_position (48, signed), y_position (48, signed), heading (32).
  output logic [OUT_W-1:0]     out_tdata,
  // Register port.
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [CFG_AW-1:0]    cfg_paddr,
  input  logic [CFG_DW-1:0]    cfg_pwdata,
  output logic [CFG_DW-1:0]    cfg_prdata,
  output logic                 cfg_pready
);

  // Twice the centre travel is (left - right) * distance_gain.
  localparam int T_W     = COUNT_BITS + 26;
  localparam int D_W     = T_W + 1;
  localparam int SUM_W   = ((D_W > POS_W) ? D_W : POS_W) + 1;
  localparam int A_SHIFT = 32 - ANGLE_BITS;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - POS_W + 1){1'b0}}, {(POS_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W - POS_W + 1){1'b1}}, {(POS_W - 1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROT  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_UPD  = 4'b1000
  } odo_state_t;

  odo_state_t state_r, state_nxt;

  // Configuration registers.
  logic [GAIN_W-1:0]       dist_gain_r;
  logic [GAIN_W-1:0]       head_gain_r;
  logic signed [POS_W-1:0] start_x_r;
  logic signed [POS_W-1:0] start_y_r;
  logic [HEAD_W-1:0]       start_head_r;

  // Pose.
  logic signed [POS_W-1:0] pos_x_r, pos_x_nxt;
  logic signed [POS_W-1:0] pos_y_r, pos_y_nxt;
  logic [ANGLE_BITS-1:0]   angle_r, angle_nxt;

  // Per-update operands captured at the input beat.
  logic signed [T_W-1:0]   t2_r;
  logic [ANGLE_BITS-1:0]   dang_r;

  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]        out_tdata_r;

  logic                    cfg_wr;
  logic [2:0]              cfg_idx;
  logic                    in_acc;
  logic                    upd_go;

  logic signed [COUNT_BITS-1:0] left_cnt, right_cnt;
  logic signed [COUNT_BITS:0]   cnt_diff, cnt_sum;
  logic signed [T_W-1:0]        t2_full;
  logic signed [T_W-1:0]        dang_full;

  logic signed [CW-1:0]    cos_v, sin_v;
  logic                    rot_done;
  logic signed [D_W-1:0]   dx, dy;
  logic                    mul_done_x, mul_done_y;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [31:0]             ang32;

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_pready = 1'b1;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;

  // The pose may move on only when the output register is free or being emptied.
  assign upd_go = (state_r == ST_UPD) && (!out_tvalid_r || out_tready);

  // The heading held before the update drives the rotation.
  assign ang32 = 32'(angle_r) << A_SHIFT;

  always_comb begin
    left_cnt  = in_tdata[COUNT_BITS-1:0];
    right_cnt = in_tdata[2*COUNT_BITS-1:COUNT_BITS];
    cnt_diff  = (COUNT_BITS + 1)'(left_cnt) - (COUNT_BITS + 1)'(right_cnt);
    cnt_sum   = (COUNT_BITS + 1)'(left_cnt) + (COUNT_BITS + 1)'(right_cnt);
    t2_full   = cnt_diff * $signed({1'b0, dist_gain_r});
    dang_full = cnt_sum * $signed({1'b0, head_gain_r});
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_ROT;
      ST_ROT:  if (rot_done) state_nxt = ST_MUL;
      ST_MUL:  if (mul_done_x) state_nxt = ST_UPD;
      ST_UPD:  if (upd_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  odo_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (in_acc),
    .ang_i   (ang32),
    .cos_o   (cos_v),
    .sin_o   (sin_v),
    .done_o  (rot_done)
  );

  odo_sermul #(.T_W(T_W)) u_mul_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (rot_done),
    .t_i     (t2_r),
    .c_i     (cos_v),
    .d_o     (dx),
    .done_o  (mul_done_x)
  );

  odo_sermul #(.T_W(T_W)) u_mul_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (rot_done),
    .t_i     (t2_r),
    .c_i     (sin_v),
    .d_o     (dy),
    .done_o  (mul_done_y)
  );

  // Saturating position update and wrapping heading update.
  always_comb begin
    sum_x = SUM_W'(pos_x_r) + SUM_W'(dx);
    sum_y = SUM_W'(pos_y_r) + SUM_W'(dy);
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    angle_nxt = angle_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (upd_go) begin
      priority if (sum_x > SAT_HI) begin
        pos_x_nxt = SAT_HI[POS_W-1:0];
      end else if (sum_x < SAT_LO) begin
        pos_x_nxt = SAT_LO[POS_W-1:0];
      end else begin
        pos_x_nxt = sum_x[POS_W-1:0];
      end
      priority if (sum_y > SAT_HI) begin
        pos_y_nxt = SAT_HI[POS_W-1:0];
      end else if (sum_y < SAT_LO) begin
        pos_y_nxt = SAT_LO[POS_W-1:0];
      end else begin
        pos_y_nxt = sum_y[POS_W-1:0];
      end
      angle_nxt = angle_r + dang_r;
      out_tvalid_nxt = 1'b1;
    end
    // Writing a start register presets the matching part of the pose.
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_X:       pos_x_nxt = cfg_pwdata[POS_W-1:0];
        REG_START_Y:       pos_y_nxt = cfg_pwdata[POS_W-1:0];
        REG_START_HEADING: angle_nxt = cfg_pwdata[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      dist_gain_r  <= '0;
      head_gain_r  <= '0;
      start_x_r    <= '0;
      start_y_r    <= '0;
      start_head_r <= '0;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      angle_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
      angle_r      <= angle_nxt;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_DISTANCE_GAIN: dist_gain_r  <= cfg_pwdata[GAIN_W-1:0];
          REG_HEADING_GAIN:  head_gain_r  <= cfg_pwdata[GAIN_W-1:0];
          REG_START_X:       start_x_r    <= cfg_pwdata[POS_W-1:0];
          REG_START_Y:       start_y_r    <= cfg_pwdata[POS_W-1:0];
          REG_START_HEADING: start_head_r <= cfg_pwdata[HEAD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Operand and result payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      t2_r   <= t2_full;
      dang_r <= dang_full[ANGLE_BITS-1:0];
    end
    if (upd_go) begin
      out_tdata_r <= {32'(angle_nxt), pos_y_nxt, pos_x_nxt};
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DISTANCE_GAIN: cfg_prdata = CFG_DW'(dist_gain_r);
      REG_HEADING_GAIN:  cfg_prdata = CFG_DW'(head_gain_r);
      REG_START_X:       cfg_prdata = CFG_DW'(start_x_r);
      REG_START_Y:       cfg_prdata = CFG_DW'(start_y_r);
      REG_START_HEADING: cfg_prdata = CFG_DW'(start_head_r);
      default:           cfg_prdata = '0;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // An accepted beat always starts the rotation on the next cycle.
  `ASSERT_NEXT(a_acc_to_rot, clk, rst_n, in_acc, state_r == ST_ROT)
  // The rotation only finishes while the controller waits for it.
  `ASSERT_IMPLIES(a_rot_done_state, clk, rst_n, rot_done, state_r == ST_ROT)
  // Both multipliers run in lock-step.
  `ASSERT_ALWAYS(a_mul_lockstep, clk, rst_n, mul_done_x == mul_done_y)
  // A completed update leaves a result waiting and the controller idle.
  `ASSERT_NEXT(a_upd_result, clk, rst_n, upd_go, out_tvalid_r && state_r == ST_IDLE)

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import odo_pkg::*;

  // Predictor constants: CORDIC start gain, rotation steps and the 48-bit position limits.
  localparam longint ROT_GAIN = 64'sd652032874;
  localparam int ROT_STEPS = 28;
  localparam longint POS_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint POS_LO = -POS_HI - 1;
  localparam longint ATAN_STEP [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };
  // Realistic gains: one length unit per count, and a full turn per 2400 counts.
  localparam logic [23:0] UNIT_TRAVEL = 24'd65536;
  localparam logic [23:0] TURN_PER_COUNT = 24'd1789570;
  // A watchdog fires once this many cycles pass without any beat or register write.
  localparam int STALL_LIMIT = 4000;
  localparam int BLOCKS = 12;
  localparam int BLOCK_ITEMS = 140;

  // One pose as it travels on out_tdata: x in the lowest bits, then y, then heading.
  typedef struct packed {
    logic [31:0]        heading;
    logic signed [47:0] y;
    logic signed [47:0] x;
  } pose_t;

  // Tracks the vehicle pose exactly as the block should, and holds the poses that
  // are still owed on the result channel.
  class odometry_tracker;
    logic [23:0] dist_gain;
    logic [23:0] turn_gain;
    longint pos_x;
    longint pos_y;
    logic [31:0] angle;
    pose_t pending_poses[$];
    int errors;
    int updates;
    int checked;
    int clamped;
    int writes;

    function new();
      dist_gain = '0;
      turn_gain = '0;
      pos_x = 0;
      pos_y = 0;
      angle = '0;
      errors = 0;
      updates = 0;
      checked = 0;
      clamped = 0;
      writes = 0;
    endfunction

    function int pending();
      return pending_poses.size();
    endfunction

    function void load_register(logic [2:0] idx, logic [63:0] val);
      logic signed [47:0] preset;
      preset = val[47:0];
      writes++;
      case (idx)
        REG_DISTANCE_GAIN: dist_gain = val[23:0];
        REG_HEADING_GAIN: turn_gain = val[23:0];
        REG_START_X: pos_x = preset;
        REG_START_Y: pos_y = preset;
        REG_START_HEADING: angle = val[31:0];
        default: ;
      endcase
    endfunction

    // Rotation-mode CORDIC on the low 30 bits, then the quadrant folds the result round.
    function void sin_cos(input logic [31:0] ang, output longint c, output longint s);
      longint x, y, z, xs, ys;
      x = ROT_GAIN;
      y = 0;
      z = longint'(ang[29:0]);
      for (int i = 0; i < ROT_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_STEP[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_STEP[i];
        end
      end
      case (odo_quad_t'(ang[31:30]))
        QUAD_I: begin
          c = x;
          s = y;
        end
        QUAD_II: begin
          c = -y;
          s = x;
        end
        QUAD_III: begin
          c = -x;
          s = -y;
        end
        default: begin
          c = y;
          s = -x;
        end
      endcase
    endfunction

    // travel * trig / 2^31, rounded towards zero; the product needs more than 64 bits.
    function longint scaled_travel(longint travel, longint trig);
      logic [63:0] ut, uc;
      logic [127:0] prod;
      bit neg;
      neg = (travel < 0) != (trig < 0);
      ut = (travel < 0) ? -travel : travel;
      uc = (trig < 0) ? -trig : trig;
      prod = ({64'd0, ut} * {64'd0, uc}) >> 31;
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function longint clamp_pos(longint v);
      if (v > POS_HI) return POS_HI;
      if (v < POS_LO) return POS_LO;
      return v;
    endfunction

    function void advance_pose(logic signed [15:0] left, logic signed [15:0] right);
      longint l, r, twice_travel, c, s;
      pose_t p;
      l = left;
      r = right;
      twice_travel = (l - r) * longint'(dist_gain);
      // The move uses the heading held before this update.
      sin_cos(angle, c, s);
      pos_x = clamp_pos(pos_x + scaled_travel(twice_travel, c));
      pos_y = clamp_pos(pos_y + scaled_travel(twice_travel, s));
      angle = angle + 32'((l + r) * longint'(turn_gain));
      if (pos_x == POS_HI || pos_x == POS_LO || pos_y == POS_HI || pos_y == POS_LO)
        clamped++;
      p.x = pos_x[47:0];
      p.y = pos_y[47:0];
      p.heading = angle;
      pending_poses.push_back(p);
      updates++;
    endfunction

    function void check_pose(pose_t got);
      pose_t want;
      checked++;
      if (pending_poses.size() == 0) begin
        $display("%0t: pose beat with none expected: x %0d y %0d heading %h",
                 $time, got.x, got.y, got.heading);
        errors++;
        return;
      end
      want = pending_poses.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: x_position expected %0d got %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: y_position expected %0d got %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.heading !== want.heading) begin
        $display("%0t: heading expected %h got %h", $time, want.heading, got.heading);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // tdata: left_count [15:0], right_count [31:16], both signed.
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // tdata: x_position [47:0], y_position [95:48], heading [127:96].
  logic [OUT_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  odometry_tracker board;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int stall_cycles = 0;

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  differential_drive_odometry dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // The receiver stalls at random, a fresh decision every cycle, so that back-pressure
  // holds results in the output register and delays the pose update.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Everything that crosses an interface is sampled here, at the clock edge, with the
  // values that were settled before the edge. Results are checked before the input of
  // the same edge is noted, as a result can never belong to an input taken alongside it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        board.check_pose(out_tdata);
      if (in_tvalid && in_tready)
        board.advance_pose(in_tdata[15:0], in_tdata[31:16]);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        board.load_register(cfg_paddr[5:3], cfg_pwdata);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (stall_cycles < STALL_LIMIT)
      @(negedge clk);
    $display("tb: failure");
    $finish;
  end

  // A register write: setup cycle, then access cycle until pready. The task then idles
  // with psel low, so that back-to-back writes never reassign psel within one step.
  task automatic write_register(input logic [2:0] idx, input logic [63:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one update beat. tvalid only drops when the sender decides to idle, so a
  // run of beats without gaps keeps it high throughout.
  task automatic send_update(input logic signed [15:0] left, input logic signed [15:0] right);
    if ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {right, left};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering beats and waits until every owed pose has come back, leaving the
  // block idle and safe for register writes. The first look is taken at the falling
  // edge, once the beat accepted at the last rising edge has been noted.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    @(posedge clk);
  endtask

  function automatic logic [15:0] corner_count();
    case ($urandom_range(3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  // Most updates look like real driving: the left and right counts have opposite signs
  // for forward travel, with a small common part that turns the vehicle. The rest are
  // arbitrary counts and the extremes of the field.
  task automatic send_random_update();
    logic signed [15:0] l, r;
    int v, w, pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      v = $urandom_range(600);
      w = $urandom_range(60);
      v = v - 300;
      w = w - 30;
      l = 16'(v + w);
      r = 16'(w - v);
    end else if (pick < 90) begin
      l = 16'($urandom);
      r = 16'($urandom);
    end else begin
      l = corner_count();
      r = corner_count();
    end
    send_update(l, r);
  endtask

  // Four kinds of setting in turn: realistic gains, both gains at full scale with the
  // position preset at or near a limit, zero gains, and random gains and presets.
  task automatic load_settings(input int k);
    logic [23:0] dg, hg;
    logic [63:0] sx, sy;
    sx = {$urandom, $urandom};
    sy = {$urandom, $urandom};
    dg = 24'($urandom);
    hg = 24'($urandom);
    case (k % 4)
      0: begin
        dg = UNIT_TRAVEL;
        hg = TURN_PER_COUNT;
        sx = '0;
        sy = '0;
      end
      1: begin
        dg = '1;
        hg = '1;
        sx = (k & 4) ? 64'(POS_LO) : 64'(POS_HI - longint'($urandom_range(1000)));
        sy = (k & 4) ? 64'(POS_HI) : 64'(POS_LO + longint'($urandom_range(1000)));
      end
      2: begin
        dg = '0;
        hg = '0;
      end
      default: ;
    endcase
    write_register(REG_DISTANCE_GAIN, 64'(dg));
    write_register(REG_HEADING_GAIN, 64'(hg));
    write_register(REG_START_X, sx);
    write_register(REG_START_Y, sy);
    write_register(REG_START_HEADING, {32'd0, $urandom});
  endtask

  initial begin
    logic [31:0] quadrant_heads [4];
    quadrant_heads = '{32'h4000_0000, 32'h8000_0000, 32'hC000_0000, 32'hFFFF_FFFF};
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 35;
    sink_idle_pct = 75;

    // Directed part. Realistic gains first, over the extremes of both counts.
    write_register(REG_DISTANCE_GAIN, 64'(UNIT_TRAVEL));
    write_register(REG_HEADING_GAIN, 64'(TURN_PER_COUNT));
    send_update(16'sd0, 16'sd0);
    send_update(16'sd1, -16'sd1);
    send_update(16'sh7FFF, 16'sh8000);
    send_update(16'sh8000, 16'sh7FFF);
    send_update(16'sh7FFF, 16'sh7FFF);
    send_update(16'sh8000, 16'sh8000);
    send_update(-16'sd1, 16'sd0);
    send_update(16'sd0, -16'sd1);
    send_update(16'sd12345, -16'sd12345);

    // A heading preset loads the live angle at once; one move from each quadrant edge.
    foreach (quadrant_heads[i]) begin
      settle();
      write_register(REG_START_HEADING, {32'd0, quadrant_heads[i]});
      send_update(16'sd1000, -16'sd1000);
    end

    // Full-scale travel from just inside the limits at 315 degrees: X runs into the
    // top of its range and Y into the bottom, then a reverse move backs off both.
    settle();
    write_register(REG_DISTANCE_GAIN, 64'hFF_FFFF);
    write_register(REG_HEADING_GAIN, 64'd0);
    write_register(REG_START_X, 64'(POS_HI - 5));
    write_register(REG_START_Y, 64'(POS_LO + 5));
    write_register(REG_START_HEADING, {32'd0, 32'hE000_0000});
    repeat (3) send_update(16'sh7FFF, 16'sh8000);
    send_update(16'sh8000, 16'sh7FFF);

    // Writes beyond the last register must leave gains and pose alone.
    settle();
    for (int i = int'(REG_START_HEADING) + 1; i < 8; i++)
      write_register(3'(i), '1);
    send_update(16'sd300, -16'sd200);
    send_update(-16'sd50, 16'sd70);
    settle();

    // Random part: four settings per idling pattern, the receiver slow first, then the
    // sender, then neither.
    for (int b = 0; b < BLOCKS; b++) begin
      case (b / 4)
        0: begin
          src_idle_pct = 35;
          sink_idle_pct = 75;
        end
        1: begin
          src_idle_pct = 75;
          sink_idle_pct = 35;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      load_settings(b);
      repeat (BLOCK_ITEMS) send_random_update();
      settle();
    end

    // Let a stray late beat show itself before the verdict.
    repeat (100) @(posedge clk);
    $display("tb: %0d updates sent, %0d pose beats checked, %0d register writes",
             board.updates, board.checked, board.writes);
    $display("tb: %0d poses ended at a position limit", board.clamped);
    if (board.errors == 0 && board.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
